[rtl/utf8ld_pkg.sv]
// Shared beat types and byte-class constants for the lenient UTF-8 decoder.
package utf8ld_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic        last_of_run;
	} out_item_t;

	// Results produced by one input beat, handed from the decoder to the result queue.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_MARK    = 8'h80;
	localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

endpackage

[rtl/utf8ld_decode.sv]
// Input register, sequence state and the single-pass byte decoder.
module utf8ld_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  utf8ld_pkg::in_item_t byte_data,
	input  logic                room,
	output utf8ld_pkg::push_t   push
);
	import utf8ld_pkg::*;

	typedef struct packed {
		logic        emit;
		logic [1:0]  remain;
		logic [14:0] partial;
	} fresh_t;

	logic        valid_s1;
	in_item_t    item_s1;
	logic [1:0]  remain_q;
	logic [14:0] partial_q;
	logic [7:0]  lead_q;

	logic [1:0]  remain_d;
	logic [14:0] partial_d;
	logic [7:0]  lead_d;
	logic        advance;
	logic [7:0]  b;
	logic [20:0] full;
	fresh_t      fr;

	function automatic fresh_t decode_fresh(input logic [7:0] v);
		fresh_t f;
		f = '0;
		unique case (v) inside
			8'b0???????: f.emit = 1'b1;
			8'b110?????: begin
				f.remain  = 2'd1;
				f.partial = {10'd0, v[4:0]};
			end
			8'b1110????: begin
				f.remain  = 2'd2;
				f.partial = {11'd0, v[3:0]};
			end
			8'b11110???: begin
				f.remain  = 2'd3;
				f.partial = {12'd0, v[2:0]};
			end
			default: f.emit = 1'b1;
		endcase
		return f;
	endfunction

	assign advance    = valid_s1 & room;
	assign byte_stall = valid_s1 & ~room;
	assign b          = item_s1.text_byte;
	assign full       = {partial_q, b[5:0]};
	assign fr         = decode_fresh(b);

	always_comb begin
		push      = '0;
		remain_d  = remain_q;
		partial_d = partial_q;
		lead_d    = lead_q;
		if (item_s1.end_of_text) begin
			if (remain_q != 2'd0) begin
				push.count             = 2'd1;
				push.first.code_point  = {13'd0, lead_q};
				remain_d               = 2'd0;
				partial_d              = '0;
				lead_d                 = '0;
			end
		end else if (remain_q == 2'd0) begin
			if (fr.emit) begin
				push.count            = 2'd1;
				push.first.code_point = {13'd0, b};
			end else begin
				remain_d  = fr.remain;
				partial_d = fr.partial;
				lead_d    = b;
			end
		end else if ((b & CONT_MASK) == CONT_MARK) begin
			remain_d = remain_q - 2'd1;
			if (remain_q == 2'd1) begin
				push.count            = 2'd1;
				push.first.code_point = full;
				partial_d             = '0;
				lead_d                = '0;
			end else begin
				partial_d = full[14:0];
			end
		end else begin
			// A broken sequence gives back its lead byte, then the new byte starts over.
			push.first.code_point = {13'd0, lead_q};
			if (fr.emit) begin
				push.count             = 2'd2;
				push.second.code_point = {13'd0, b};
				remain_d               = 2'd0;
				partial_d              = '0;
				lead_d                 = '0;
			end else begin
				push.count = 2'd1;
				remain_d   = fr.remain;
				partial_d  = fr.partial;
				lead_d     = b;
			end
		end
		push.first.last_of_run  = (push.count == 2'd1);
		push.second.last_of_run = (push.count == 2'd2);
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall) begin
			item_s1 <= byte_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q  <= 2'd0;
			partial_q <= '0;
			lead_q    <= '0;
		end else if (advance) begin
			remain_q  <= remain_d;
			partial_q <= partial_d;
			lead_q    <= lead_d;
		end
	end

endmodule

[rtl/utf8ld_queue.sv]
// Four-entry result queue that takes up to two results a cycle and gives one, unless cp_stall holds it.
module utf8ld_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8ld_pkg::push_t    push,
	output logic                 room,
	output logic                 cp_valid,
	input  logic                 cp_stall,
	output utf8ld_pkg::out_item_t cp_data
);
	import utf8ld_pkg::*;

	out_item_t  entry_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] wr_next;

	assign cp_valid = (count_q != 3'd0);
	assign cp_data  = entry_q[rd_q];
	assign pop      = cp_valid & ~cp_stall;
	// Room for a full two-result beat is kept before a new byte moves on.
	assign room     = (count_q <= 3'd2);
	assign wr_next  = wr_q + 2'd1;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 2'd0;
			rd_q    <= 2'd0;
			count_q <= 3'd0;
		end else begin
			wr_q    <= wr_q + push.count;
			rd_q    <= rd_q + {1'b0, pop};
			count_q <= count_q + {1'b0, push.count} - {2'd0, pop};
		end
	end

endmodule

[rtl/utf8_lenient_decoder.sv]
// Top level: a byte register feeding the decoder, then a small result queue.
// A byte taken into the byte register is decoded combinationally and its results are
// written into the queue, whose head is offered on cp_data. Throughput: one byte per cycle
// while results are taken at one per cycle; a broken sequence can yield two results, which
// the four-entry queue absorbs, and byte_stall holds bytes while it holds three or more.
// Reset clears the open sequence, the byte register's valid flag and the queue at once.
module utf8_lenient_decoder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  utf8ld_pkg::in_item_t  byte_data,
	output logic                  cp_valid,
	input  logic                  cp_stall,
	output utf8ld_pkg::out_item_t cp_data
);
	import utf8ld_pkg::*;

	push_t push;
	logic  room;

	utf8ld_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.room       (room),
		.push       (push)
	);

	utf8ld_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.cp_valid (cp_valid),
		.cp_stall (cp_stall),
		.cp_data  (cp_data)
	);

endmodule

[dv/utf8_lenient_decoder_checker.sv]
// Checker for the lenient UTF-8 decoder: predicts code points from byte beats and compares them.
`timescale 1ns / 1ps

module utf8_lenient_decoder_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic                  byte_stall,
	input  utf8ld_pkg::in_item_t  byte_data,
	input  logic                  cp_valid,
	input  logic                  cp_stall,
	input  utf8ld_pkg::out_item_t cp_data,
	output int                    fail_count,
	output int                    due_count
);
	import utf8ld_pkg::*;

	// Decoder state as the byte stream has left it.
	logic [14:0] open_payload;
	logic [1:0]  open_left;
	logic [7:0]  open_lead;

	out_item_t code_points_due[$];
	int        mismatch_count = 0;

	assign fail_count = mismatch_count;

	// Decodes a byte with no sequence open. Returns 1 when the byte stands for
	// itself, 0 when it opens a sequence.
	function automatic logic open_or_pass(logic [7:0] b);
		if (b[7:5] == 3'b110) begin
			open_left = 2'd1;
			open_payload = {10'd0, b[4:0]};
			open_lead = b;
			return 1'b0;
		end
		if (b[7:4] == 4'b1110) begin
			open_left = 2'd2;
			open_payload = {11'd0, b[3:0]};
			open_lead = b;
			return 1'b0;
		end
		if (b[7:3] == 5'b11110) begin
			open_left = 2'd3;
			open_payload = {12'd0, b[2:0]};
			open_lead = b;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic decode_beat(in_item_t beat);
		out_item_t   first_cp;
		out_item_t   second_cp;
		int          n;
		logic [7:0]  b;
		logic [20:0] full;
		n = 0;
		b = beat.text_byte;
		first_cp = '0;
		second_cp = '0;
		if (beat.end_of_text) begin
			if (open_left != 2'd0) begin
				first_cp.code_point = {13'd0, open_lead};
				n = 1;
				open_left = 2'd0;
				open_payload = '0;
				open_lead = '0;
			end
		end else if (open_left == 2'd0) begin
			if (open_or_pass(b)) begin
				first_cp.code_point = {13'd0, b};
				n = 1;
			end
		end else if ((b & CONT_MASK) == CONT_MARK) begin
			full = {open_payload, b[5:0]};
			open_left = open_left - 2'd1;
			if (open_left == 2'd0) begin
				first_cp.code_point = full;
				n = 1;
				open_payload = '0;
				open_lead = '0;
			end else begin
				open_payload = full[14:0];
			end
		end else begin
			// A broken sequence gives up its lead as Latin-1; the byte starts over.
			first_cp.code_point = {13'd0, open_lead};
			n = 1;
			open_left = 2'd0;
			open_payload = '0;
			open_lead = '0;
			if (open_or_pass(b)) begin
				second_cp.code_point = {13'd0, b};
				n = 2;
			end
		end
		first_cp.last_of_run = (n == 1);
		second_cp.last_of_run = 1'b1;
		if (n >= 1)
			code_points_due.insert(code_points_due.size(), first_cp);
		if (n == 2)
			code_points_due.insert(code_points_due.size(), second_cp);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			open_left = 2'd0;
			open_payload = '0;
			open_lead = '0;
			code_points_due.delete();
			due_count <= 0;
		end else begin
			if (cp_valid && !cp_stall) begin
				if (code_points_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected code point beat: code_point=%06h last_of_run=%b",
							cp_data.code_point, cp_data.last_of_run);
				end else begin
					want = code_points_due.pop_front();
					if (cp_data.code_point !== want.code_point ||
						cp_data.last_of_run !== want.last_of_run) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("code point mismatch: expected %06h/%b, got %06h/%b",
								want.code_point, want.last_of_run,
								cp_data.code_point, cp_data.last_of_run);
					end
				end
			end
			if (byte_valid && !byte_stall)
				decode_beat(byte_data);
			due_count <= code_points_due.size();
		end
	end

endmodule

[dv/utf8_lenient_decoder_tb.sv]
// Testbench top for the lenient UTF-8 decoder: byte stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module utf8_lenient_decoder_tb;
	import utf8ld_pkg::*;

	localparam int RANDOM_BEATS = 650;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 300;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      cp_valid;
	logic      cp_stall = 1'b0;
	out_item_t cp_data;
	int        fail_count;
	int        due_count;
	int        cycle_count = 0;

	in_item_t text_beats[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	utf8_lenient_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.cp_valid  (cp_valid),
		.cp_stall  (cp_stall),
		.cp_data   (cp_data)
	);

	utf8_lenient_decoder_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.cp_valid  (cp_valid),
		.cp_stall  (cp_stall),
		.cp_data   (cp_data),
		.fail_count(fail_count),
		.due_count (due_count)
	);

	task automatic add_byte(logic [7:0] b);
		in_item_t beat;
		beat.text_byte = b;
		beat.end_of_text = 1'b0;
		text_beats.insert(text_beats.size(), beat);
	endtask

	task automatic add_end(logic [7:0] junk);
		in_item_t beat;
		beat.text_byte = junk;
		beat.end_of_text = 1'b1;
		text_beats.insert(text_beats.size(), beat);
	endtask

	// Lead byte for a sequence of conts continuation bytes, then taken of them.
	task automatic add_char(int conts, int taken);
		logic [7:0] lead;
		case (conts)
			1: lead = 8'hC0 | 8'($urandom_range(0, 31));
			2: lead = 8'hE0 | 8'($urandom_range(0, 15));
			default: lead = 8'hF0 | 8'($urandom_range(0, 7));
		endcase
		add_byte(lead);
		repeat (taken)
			add_byte(8'h80 | 8'($urandom_range(0, 63)));
	endtask

	task automatic build_text();
		int         kind;
		int         conts;
		int         goal;
		logic [7:0] b;
		// ASCII and stray bytes at the edges of their ranges.
		add_byte(8'h00);
		add_byte(8'h7F);
		add_byte(8'h80);
		add_byte(8'hFF);
		// Complete sequences, the last one at the top of the code point range.
		add_byte(8'hC2); add_byte(8'hA9);
		add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);
		add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
		// Broken by ASCII, by a high stray byte, and by a new lead.
		add_byte(8'hC3); add_byte(8'h41);
		add_byte(8'hE2); add_byte(8'h82); add_byte(8'hFF);
		add_byte(8'hE1); add_byte(8'hC3); add_byte(8'hA9);
		// End of text with a sequence open, then with none open.
		add_byte(8'hF0); add_byte(8'h9F); add_end(8'h00);
		add_end(8'hAA);

		goal = text_beats.size() + RANDOM_BEATS;
		while (text_beats.size() < goal) begin
			kind = $urandom_range(0, 99);
			conts = $urandom_range(1, 3);
			if (kind < 28) begin
				add_byte(8'($urandom_range(0, 127)));
			end else if (kind < 68) begin
				add_char(conts, conts);
			end else if (kind < 76) begin
				if ($urandom_range(0, 1))
					add_byte(8'($urandom_range(8'h80, 8'hBF)));
				else
					add_byte(8'($urandom_range(8'hF8, 8'hFF)));
			end else if (kind < 87) begin
				add_char(conts, $urandom_range(0, conts - 1));
				do
					b = 8'($urandom_range(0, 255));
				while (b[7:6] == 2'b10);
				add_byte(b);
			end else if (kind < 92) begin
				add_char(conts, $urandom_range(0, conts - 1));
				add_end(8'($urandom_range(0, 255)));
			end else if (kind < 95) begin
				add_end(8'($urandom_range(0, 255)));
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[utf8_lenient_decoder] ERROR");
		$finish;
	end

	// Result side: stall patterns of varying shape, with one long hold-off
	// early on so that the result queue fills and the byte input backs up.
	initial begin : result_side
		int mode;
		int span;
		int rx_cycles;
		bit held;
		rx_cycles = 0;
		held = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(5, 60);
			for (int i = 0; i < span; i++) begin
				case (mode)
					0: cp_stall <= 1'b0;
					1: cp_stall <= ($urandom_range(0, 2) == 0);
					2: cp_stall <= i[0];
					default: cp_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
				rx_cycles++;
			end
			if (!held && rx_cycles >= 300) begin
				held = 1'b1;
				cp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_cycles += HOLD_CYCLES;
			end
		end
	end

	initial begin : byte_side
		int idx;
		int burst;
		int gap;
		build_text();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idx = 0;
		while (idx < text_beats.size()) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && idx < text_beats.size()) begin
				byte_valid <= 1'b1;
				byte_data <= text_beats[idx];
				@(posedge clk);
				while (byte_stall)
					@(posedge clk);
				idx++;
				burst--;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		byte_valid <= 1'b0;

		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[utf8_lenient_decoder] OK");
		else
			$display("[utf8_lenient_decoder] ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/utf8ld_pkg.sv
rtl/utf8ld_decode.sv
rtl/utf8ld_queue.sv
rtl/utf8_lenient_decoder.sv
dv/utf8_lenient_decoder_checker.sv
dv/utf8_lenient_decoder_tb.sv
